// ===== hw/rtl/tvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types and constants of the trapezoidal velocity profile planner.
// ----------------------------------------------------------------------------
package tvp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NPTS       = 5;
    localparam int PT_IDX_W   = $clog2(NPTS);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE = 1'd1;

    localparam logic [31:0] LIMIT_RESET = 32'd65536;
    localparam logic [63:0] TIME_INF    = 64'd1 << 60;

    typedef struct packed {
        logic [31:0]        path_length;
        logic signed [31:0] start_velocity;
        logic signed [31:0] target_velocity;
        logic               stop_at_end;
    } plan_req_t;

    typedef struct packed {
        logic [31:0]        point_time;
        logic signed [31:0] point_velocity;
        logic               last_point;
        logic               profile_complete;
        logic               time_saturated;
    } plan_pnt_t;

    // classified request: magnitudes and sign flags
    typedef struct packed {
        logic [31:0] len;
        logic [31:0] u;
        logic [31:0] w;
        logic        neg0;
        logic        negv;
        logic        stop;
        logic        opp;
    } plan_job_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    // time numerator: value scaled by the fraction bits
    function automatic logic [63:0] tnum(input logic [32:0] n);
        logic [63:0] ext;
        ext = {31'd0, n};
        return ext << FRAC_BITS;
    endfunction

endpackage

// ===== hw/rtl/trapezoidal_velocity_profile_core.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile_core
// Plans a trapezoidal or triangular velocity profile per request and emits
// its breakpoints.
// ----------------------------------------------------------------------------
// Each request yields two to five breakpoints (time, velocity) in Q16.16,
// the last flagged with last_point. The profile math runs on one shared
// 64/33-bit divider at one quotient bit per cycle (up to ten quotients per
// request) and one floor square root unit at one bit per cycle. Breakpoints
// then leave one per cycle through the output register while the receiver
// is ready. Two further requests are queued while one is planned, so the
// request side takes up to two requests while results wait. accel_limit
// (index 0) and brake_limit (index 1) reset to 1.0; a limit of zero acts
// as one LSB. Write them only while no request is in flight.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_profile_core
    import tvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  plan_req_t            req_data,
    output logic                 pnt_valid,
    input  logic                 pnt_ready,
    output plan_pnt_t            pnt_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [31:0] accel_reg, accel_next;
    logic [31:0] brake_reg, brake_next;
    logic [31:0] accel_eff, brake_eff;
    logic        job_valid, job_ready;
    plan_job_t   job;
    div_req_t    div_req;
    div_rsp_t    div_rsp;
    sqrt_req_t   sqrt_req;
    sqrt_rsp_t   sqrt_rsp;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        accel_next = accel_reg;
        brake_next = brake_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACCEL: accel_next = cfg_data;
                REG_BRAKE: brake_next = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= LIMIT_RESET;
            brake_reg <= LIMIT_RESET;
        end
        else
        begin
            accel_reg <= accel_next;
            brake_reg <= brake_next;
        end
    end

    assign accel_eff = (accel_reg == 32'd0) ? 32'd1 : accel_reg;
    assign brake_eff = (brake_reg == 32'd0) ? 32'd1 : brake_reg;

    tvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    tvp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tvp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    tvp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .accel     (accel_eff),
        .brake     (brake_eff),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .sqrt_req  (sqrt_req),
        .sqrt_rsp  (sqrt_rsp),
        .pnt_valid (pnt_valid),
        .pnt_ready (pnt_ready),
        .pnt_data  (pnt_data)
    );

endmodule

// ===== hw/rtl/tvp_div.sv =====
// ----------------------------------------------------------------------------
// tvp_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module tvp_div
    import tvp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [32:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic [33:0] trial;

    assign trial = {rem_reg, q_reg[63]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 33'(trial - {1'b0, den_reg});
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[32:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// ===== hw/rtl/tvp_sqrt.sv =====
// ----------------------------------------------------------------------------
// tvp_sqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tvp_sqrt
    import tvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = req.x;
            r_next    = '0;
            bit_next  = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[31:0];

endmodule

// ===== hw/rtl/tvp_front.sv =====
// ----------------------------------------------------------------------------
// tvp_front
// Request intake: splits velocities into magnitude and sign, flags a
// direction reversal and queues the classified request.
// ----------------------------------------------------------------------------
module tvp_front
    import tvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  plan_req_t req_data,
    output logic      job_valid,
    input  logic      job_ready,
    output plan_job_t job
);

    plan_job_t             fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    plan_job_t             job_in;
    logic [31:0]           v0_bits, v_bits;
    logic                  push, pop;

    assign v0_bits = req_data.start_velocity;
    assign v_bits  = req_data.target_velocity;

    always_comb
    begin
        job_in.len  = req_data.path_length;
        job_in.neg0 = v0_bits[31];
        job_in.negv = v_bits[31];
        job_in.u    = v0_bits[31] ? (~v0_bits + 32'd1) : v0_bits;
        job_in.w    = v_bits[31] ? (~v_bits + 32'd1) : v_bits;
        job_in.stop = req_data.stop_at_end;
        // zero speed never counts as a reversal
        job_in.opp  = (job_in.u != 32'd0) && (job_in.w != 32'd0) &&
                      (job_in.neg0 != job_in.negv);
    end

    assign req_ready = (count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = fifo_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ===== hw/rtl/tvp_back.sv =====
// ----------------------------------------------------------------------------
// tvp_back
// Planning sequencer: runs the profile math on a shared multiplier, divider
// and square root unit, collects the breakpoints and drains them one per
// cycle through the output register while the receiver is ready.
// ----------------------------------------------------------------------------
module tvp_back
    import tvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  plan_job_t job,
    input  logic [31:0] accel,
    input  logic [31:0] brake,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    output sqrt_req_t sqrt_req,
    input  sqrt_rsp_t sqrt_rsp,
    output logic      pnt_valid,
    input  logic      pnt_ready,
    output plan_pnt_t pnt_data
);

    typedef enum logic [26:0] {
        S_IDLE  = 27'd1 << 0,
        S_U2    = 27'd1 << 1,
        S_DZ    = 27'd1 << 2,
        S_CHK1  = 27'd1 << 3,
        S_SEBL  = 27'd1 << 4,
        S_SESQ  = 27'd1 << 5,
        S_SEDV  = 27'd1 << 6,
        S_T0    = 27'd1 << 7,
        S_W2    = 27'd1 << 8,
        S_TV    = 27'd1 << 9,
        S_DV    = 27'd1 << 10,
        S_TB    = 27'd1 << 11,
        S_DB    = 27'd1 << 12,
        S_CHK2  = 27'd1 << 13,
        S_RBL   = 27'd1 << 14,
        S_RS    = 27'd1 << 15,
        S_AS    = 27'd1 << 16,
        S_P2    = 27'd1 << 17,
        S_PK    = 27'd1 << 18,
        S_PTV   = 27'd1 << 19,
        S_PTB   = 27'd1 << 20,
        S_PPP   = 27'd1 << 21,
        S_PDB   = 27'd1 << 22,
        S_EMIT  = 27'd1 << 23,
        S_TA    = 27'd1 << 24,
        S_FIN   = 27'd1 << 25,
        S_DRAIN = 27'd1 << 26
    } back_state_t;

    back_state_t state_reg, state_next;
    logic        pend_reg, pend_next;

    logic [31:0] len_reg, len_next;
    logic [31:0] u_reg, u_next;
    logic [31:0] w_reg, w_next;
    logic        neg0_reg, neg0_next;
    logic        negv_reg, negv_next;
    logic        stop_reg, stop_next;
    logic        opp_reg, opp_next;
    logic        reduced_reg, reduced_next;
    logic        complete_reg, complete_next;
    logic [63:0] u2_reg, u2_next;
    logic [63:0] w2_reg, w2_next;
    logic [63:0] dz_reg, dz_next;
    logic [63:0] mul_reg, mul_next;
    logic [63:0] p2_reg, p2_next;
    logic [63:0] t0_reg, t0_next;
    logic [63:0] tv_reg, tv_next;
    logic [63:0] ta_reg, ta_next;
    logic [63:0] tb_reg, tb_next;
    logic [63:0] dv_reg, dv_next;
    logic [63:0] db_reg, db_next;
    logic [63:0] dsum_reg, dsum_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] peak_reg, peak_next;
    logic [31:0] sq_reg, sq_next;

    plan_pnt_t             buf_reg [NPTS];
    logic [PT_IDX_W-1:0]   k_reg, k_next;
    logic [PT_IDX_W-1:0]   idx_reg, idx_next;
    plan_pnt_t             pnt_reg, pnt_next;
    logic                  pnt_valid_reg, pnt_valid_next;

    logic [31:0]           mul_x, mul_y;
    logic [63:0]           prod;
    logic                  push_en;
    logic [63:0]           push_t;
    logic                  push_neg;
    logic [31:0]           push_mag;
    logic [PT_IDX_W-1:0]   push_idx;
    plan_pnt_t             push_pnt;
    logic [63:0]           dsum;
    logic [63:0]           gap;
    logic [64:0]           as2;
    logic [63:0]           half_u2;
    logic [63:0]           ta_val;
    logic                  w_gt_u;

    assign prod    = 64'(mul_x) * 64'(mul_y);
    assign dsum    = dv_reg + db_reg;
    assign gap     = w2_reg - u2_reg;
    assign as2     = {mul_reg, 1'b0};
    assign half_u2 = u2_reg >> 1;
    assign w_gt_u  = (w_reg > u_reg);
    assign ta_val  = (w_reg == 32'd0) ? TIME_INF : div_rsp.quot;
    assign push_idx = (state_reg == S_IDLE) ? '0 : k_reg;

    always_comb
    begin
        push_pnt.time_saturated   = (push_t[63:32] != 32'd0);
        push_pnt.point_time       = push_pnt.time_saturated ? 32'hFFFF_FFFF : push_t[31:0];
        push_pnt.point_velocity   = push_neg ? (~push_mag + 32'd1) : push_mag;
        push_pnt.last_point       = 1'b0;
        push_pnt.profile_complete = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        len_next       = len_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        neg0_next      = neg0_reg;
        negv_next      = negv_reg;
        stop_next      = stop_reg;
        opp_next       = opp_reg;
        reduced_next   = reduced_reg;
        complete_next  = complete_reg;
        u2_next        = u2_reg;
        w2_next        = w2_reg;
        dz_next        = dz_reg;
        mul_next       = mul_reg;
        p2_next        = p2_reg;
        t0_next        = t0_reg;
        tv_next        = tv_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        dv_next        = dv_reg;
        db_next        = db_reg;
        dsum_next      = dsum_reg;
        s_next         = s_reg;
        peak_next      = peak_reg;
        sq_next        = sq_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        pnt_next       = pnt_reg;
        pnt_valid_next = pnt_valid_reg;

        job_ready      = 1'b0;
        mul_x          = '0;
        mul_y          = '0;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = {1'b0, brake};
        sqrt_req.start = 1'b0;
        sqrt_req.x     = '0;
        push_en        = 1'b0;
        push_t         = '0;
        push_neg       = 1'b0;
        push_mag       = '0;

        if (pnt_ready)
        begin
            pnt_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    len_next      = job.len;
                    u_next        = job.u;
                    w_next        = job.w;
                    neg0_next     = job.neg0;
                    negv_next     = job.negv;
                    stop_next     = job.stop;
                    opp_next      = job.opp;
                    reduced_next  = 1'b0;
                    complete_next = 1'b1;
                    t0_next       = '0;
                    ta_next       = '0;
                    tb_next       = '0;
                    db_next       = '0;
                    peak_next     = job.w;
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    // start point
                    push_en       = 1'b1;
                    push_neg      = job.neg0;
                    push_mag      = job.u;
                    state_next    = S_U2;
                end
            end
            S_U2:
            begin
                mul_x      = u_reg;
                mul_y      = u_reg;
                u2_next    = prod;
                state_next = S_DZ;
            end
            S_DZ:
            begin
                div_req.num = u2_reg;
                div_req.den = {brake, 1'b0};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    dz_next    = div_rsp.quot;
                    state_next = S_CHK1;
                end
            end
            S_CHK1:
            begin
                if ((stop_reg || opp_reg) && ({32'd0, len_reg} < dz_reg))
                begin
                    state_next = S_SEBL;
                end
                else if (opp_reg)
                begin
                    state_next = S_T0;
                end
                else
                begin
                    state_next = S_W2;
                end
            end
            S_SEBL:
            begin
                mul_x      = brake;
                mul_y      = len_reg;
                mul_next   = prod;
                state_next = S_SESQ;
            end
            S_SESQ:
            begin
                sqrt_req.x = (mul_reg > half_u2) ? 64'd0 : (u2_reg - {mul_reg[62:0], 1'b0});
                if (!pend_reg)
                begin
                    sqrt_req.start = 1'b1;
                    pend_next      = 1'b1;
                end
                else if (sqrt_rsp.done)
                begin
                    pend_next  = 1'b0;
                    sq_next    = (sqrt_rsp.root > u_reg) ? u_reg : sqrt_rsp.root;
                    state_next = S_SEDV;
                end
            end
            S_SEDV:
            begin
                div_req.num = tnum({1'b0, u_reg - sq_reg});
                div_req.den = {1'b0, brake};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next     = 1'b0;
                    push_en       = 1'b1;
                    push_t        = div_rsp.quot;
                    push_neg      = neg0_reg;
                    push_mag      = sq_reg;
                    complete_next = 1'b0;
                    state_next    = S_DRAIN;
                end
            end
            S_T0:
            begin
                div_req.num = tnum({1'b0, u_reg});
                div_req.den = {1'b0, brake};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    // zero crossing point
                    pend_next  = 1'b0;
                    t0_next    = div_rsp.quot;
                    push_en    = 1'b1;
                    push_t     = div_rsp.quot;
                    len_next   = len_reg - dz_reg[31:0];
                    u_next     = '0;
                    u2_next    = '0;
                    state_next = S_W2;
                end
            end
            S_W2:
            begin
                mul_x      = w_reg;
                mul_y      = w_reg;
                w2_next    = prod;
                state_next = S_TV;
            end
            S_TV:
            begin
                if (w_gt_u)
                begin
                    div_req.num = tnum({1'b0, w_reg - u_reg});
                    div_req.den = {1'b0, accel};
                end
                else
                begin
                    div_req.num = tnum({1'b0, u_reg - w_reg});
                    div_req.den = {1'b0, brake};
                end
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    tv_next    = div_rsp.quot;
                    state_next = S_DV;
                end
            end
            S_DV:
            begin
                if (w_gt_u)
                begin
                    div_req.num = w2_reg - u2_reg;
                    div_req.den = {accel, 1'b0};
                end
                else
                begin
                    div_req.num = u2_reg - w2_reg;
                    div_req.den = {brake, 1'b0};
                end
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    dv_next    = div_rsp.quot;
                    state_next = stop_reg ? S_TB : S_CHK2;
                end
            end
            S_TB:
            begin
                div_req.num = tnum({1'b0, w_reg});
                div_req.den = {1'b0, brake};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    tb_next    = div_rsp.quot;
                    state_next = S_DB;
                end
            end
            S_DB:
            begin
                div_req.num = w2_reg;
                div_req.den = {brake, 1'b0};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    db_next    = div_rsp.quot;
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                dsum_next = dsum;
                if (dsum > {32'd0, len_reg})
                begin
                    if (u_reg > w_reg)
                    begin
                        // still too fast at path end
                        state_next = S_SEBL;
                    end
                    else
                    begin
                        reduced_next = 1'b1;
                        if (stop_reg)
                        begin
                            state_next = S_RBL;
                        end
                        else
                        begin
                            s_next     = len_reg;
                            state_next = S_AS;
                        end
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RBL:
            begin
                mul_x      = brake;
                mul_y      = len_reg;
                mul_next   = prod;
                state_next = S_RS;
            end
            S_RS:
            begin
                // meeting point of the two ramps
                div_req.num = mul_reg - half_u2;
                div_req.den = {1'b0, accel} + {1'b0, brake};
                if (mul_reg < half_u2)
                begin
                    s_next     = '0;
                    state_next = S_AS;
                end
                else if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    s_next     = div_rsp.quot[31:0];
                    state_next = S_AS;
                end
            end
            S_AS:
            begin
                mul_x      = accel;
                mul_y      = s_reg;
                mul_next   = prod;
                state_next = S_P2;
            end
            S_P2:
            begin
                // peak speed squared, clamped to the target
                if (as2 > {1'b0, gap})
                begin
                    p2_next = w2_reg;
                end
                else
                begin
                    p2_next = u2_reg + as2[63:0];
                end
                state_next = S_PK;
            end
            S_PK:
            begin
                sqrt_req.x = p2_reg;
                if (!pend_reg)
                begin
                    sqrt_req.start = 1'b1;
                    pend_next      = 1'b1;
                end
                else if (sqrt_rsp.done)
                begin
                    pend_next  = 1'b0;
                    peak_next  = (sqrt_rsp.root < u_reg) ? u_reg : sqrt_rsp.root;
                    state_next = S_PTV;
                end
            end
            S_PTV:
            begin
                div_req.num = tnum({1'b0, peak_reg - u_reg});
                div_req.den = {1'b0, accel};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    tv_next    = div_rsp.quot;
                    dv_next    = {32'd0, s_reg};
                    state_next = stop_reg ? S_PTB : S_EMIT;
                end
            end
            S_PTB:
            begin
                div_req.num = tnum({1'b0, peak_reg});
                div_req.den = {1'b0, brake};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    tb_next    = div_rsp.quot;
                    state_next = S_PPP;
                end
            end
            S_PPP:
            begin
                mul_x      = peak_reg;
                mul_y      = peak_reg;
                mul_next   = prod;
                state_next = S_PDB;
            end
            S_PDB:
            begin
                div_req.num = mul_reg;
                div_req.den = {brake, 1'b0};
                if (!pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pend_next  = 1'b0;
                    db_next    = div_rsp.quot;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                push_en  = 1'b1;
                push_t   = t0_reg + tv_reg;
                push_neg = negv_reg;
                push_mag = peak_reg;
                if (!reduced_reg && ({32'd0, len_reg} > dsum_reg))
                begin
                    state_next = S_TA;
                end
                else
                begin
                    state_next = stop_reg ? S_FIN : S_DRAIN;
                end
            end
            S_TA:
            begin
                div_req.num = tnum({1'b0, len_reg - dsum_reg[31:0]});
                div_req.den = {1'b0, w_reg};
                if (w_reg != 32'd0 && !pend_reg)
                begin
                    div_req.start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (w_reg == 32'd0 || div_rsp.done)
                begin
                    // end of cruise; zero cruise speed never ends
                    pend_next  = 1'b0;
                    ta_next    = ta_val;
                    push_en    = 1'b1;
                    push_t     = t0_reg + tv_reg + ta_val;
                    push_neg   = negv_reg;
                    push_mag   = peak_reg;
                    state_next = stop_reg ? S_FIN : S_DRAIN;
                end
            end
            S_FIN:
            begin
                push_en    = 1'b1;
                push_t     = t0_reg + tv_reg + ta_reg + tb_reg;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!pnt_valid_reg || pnt_ready)
                begin
                    pnt_next                  = buf_reg[idx_reg];
                    pnt_next.last_point       = (idx_reg == k_reg - 1'b1);
                    pnt_next.profile_complete = complete_reg;
                    pnt_valid_next            = 1'b1;
                    idx_next                  = idx_reg + 1'b1;
                    if (idx_reg == k_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en)
        begin
            k_next = push_idx + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            pnt_valid_reg <= 1'b0;
            k_reg         <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            pnt_valid_reg <= pnt_valid_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        u_reg        <= u_next;
        w_reg        <= w_next;
        neg0_reg     <= neg0_next;
        negv_reg     <= negv_next;
        stop_reg     <= stop_next;
        opp_reg      <= opp_next;
        reduced_reg  <= reduced_next;
        complete_reg <= complete_next;
        u2_reg       <= u2_next;
        w2_reg       <= w2_next;
        dz_reg       <= dz_next;
        mul_reg      <= mul_next;
        p2_reg       <= p2_next;
        t0_reg       <= t0_next;
        tv_reg       <= tv_next;
        ta_reg       <= ta_next;
        tb_reg       <= tb_next;
        dv_reg       <= dv_next;
        db_reg       <= db_next;
        dsum_reg     <= dsum_next;
        s_reg        <= s_next;
        peak_reg     <= peak_next;
        sq_reg       <= sq_next;
        pnt_reg      <= pnt_next;
        if (push_en)
        begin
            buf_reg[push_idx] <= push_pnt;
        end
    end

    assign pnt_valid = pnt_valid_reg;
    assign pnt_data  = pnt_reg;

endmodule

// ===== sim/tb_trapezoidal_velocity_profile_core.sv =====
// ----------------------------------------------------------------------------
// tb_trapezoidal_velocity_profile_core
// Drives planning requests and limit writes with random gaps and stalls,
// predicts each breakpoint run in fixed point and checks every breakpoint.
// ----------------------------------------------------------------------------
module tb_trapezoidal_velocity_profile_core;
    import tvp_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    plan_req_t            req_data;
    logic                 pnt_valid;
    logic                 pnt_ready;
    plan_pnt_t            pnt_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    trapezoidal_velocity_profile_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .pnt_valid (pnt_valid),
        .pnt_ready (pnt_ready),
        .pnt_data  (pnt_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // planner copy of the limit registers
    logic [63:0] accel_q;
    logic [63:0] brake_q;

    plan_req_t pending_reqs[$];
    plan_pnt_t expected_pnts[$];
    int        fail_count;
    int        reqs_accepted;
    int        stall_cycles;
    int        gap_cycles;
    int        hold_cycles;
    bit        hold_off;
    bit        hold_done;
    bit        req_taken;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] time_quot(input logic [63:0] num, input logic [63:0] den);
        return (num << FRAC_BITS) / den;
    endfunction

    function automatic void push_point(input logic [63:0] t, input bit neg,
                                       input logic [63:0] mag);
        plan_pnt_t p;
        logic [31:0] m;
        p.time_saturated = t > 64'hFFFF_FFFF;
        p.point_time = p.time_saturated ? 32'hFFFF_FFFF : t[31:0];
        m = mag[31:0];
        p.point_velocity = neg ? -m : m;
        p.last_point = 1'b0;
        p.profile_complete = 1'b0;
        expected_pnts = {expected_pnts, p};
    endfunction

    function automatic void add_req(input plan_req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic int rand_gap();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 60))
               : ($urandom_range(0, 1) ? 0 : int'($urandom_range(1, 3)));
    endfunction

    function automatic void push_braking_end(input logic [63:0] u, input bit neg,
                                             input logic [63:0] len, input logic [63:0] b);
        logic [63:0] u2;
        logic [63:0] bl;
        logic [63:0] rem;
        logic [63:0] sq;
        u2 = u * u;
        bl = b * len;
        rem = (bl > u2 / 2) ? 64'd0 : u2 - 2 * bl;
        sq = floor_sqrt(rem);
        if (sq > u) sq = u;
        push_point(time_quot(u - sq, b), neg, sq);
    endfunction

    function automatic void plan_profile(input plan_req_t r);
        logic [63:0] a, b, len, u, w, dz, t0, tv, dv, tb, db, ta, peak;
        logic [63:0] u2, lim, s, p2, bl, cruise_len;
        bit neg0, negv, stop, opp, complete, reduced;
        int first, n;
        a = (accel_q != 0) ? accel_q : 64'd1;
        b = (brake_q != 0) ? brake_q : 64'd1;
        len = {32'd0, r.path_length};
        neg0 = r.start_velocity[31];
        negv = r.target_velocity[31];
        stop = r.stop_at_end;
        u = neg0 ? (64'd1 << 32) - {32'd0, r.start_velocity} : {32'd0, r.start_velocity};
        w = negv ? (64'd1 << 32) - {32'd0, r.target_velocity} : {32'd0, r.target_velocity};
        opp = (u != 0) && (w != 0) && (neg0 != negv);
        complete = 1'b1;
        reduced = 1'b0;
        dz = (u * u) / (2 * b);
        t0 = 0; tb = 0; db = 0; ta = 0; peak = w;
        first = expected_pnts.size();
        push_point(64'd0, neg0, u);
        if ((stop || opp) && len < dz)
        begin
            push_braking_end(u, neg0, len, b);
            complete = 1'b0;
        end
        else
        begin
            if (opp)
            begin
                t0 = time_quot(u, b);
                push_point(t0, 1'b0, 64'd0);
                len = len - dz;
                u = 0;
            end
            if (w > u)
            begin
                tv = time_quot(w - u, a);
                dv = (w * w - u * u) / (2 * a);
            end
            else
            begin
                tv = time_quot(u - w, b);
                dv = (u * u - w * w) / (2 * b);
            end
            if (stop)
            begin
                tb = time_quot(w, b);
                db = (w * w) / (2 * b);
            end
            if (dv + db > len && u > w)
            begin
                push_braking_end(u, neg0, len, b);
                complete = 1'b0;
            end
            else
            begin
                if (dv + db > len)
                begin
                    u2 = u * u;
                    lim = w * w;
                    if (stop)
                    begin
                        bl = b * len;
                        s = (bl >= u2 / 2) ? (bl - u2 / 2) / (a + b) : 64'd0;
                    end
                    else
                        s = len;
                    if (s != 0 && a > (lim - u2) / (2 * s)) p2 = lim;
                    else p2 = u2 + 2 * a * s;
                    if (p2 > lim) p2 = lim;
                    peak = floor_sqrt(p2);
                    if (peak < u) peak = u;
                    tv = time_quot(peak - u, a);
                    dv = s;
                    if (stop)
                    begin
                        tb = time_quot(peak, b);
                        db = (peak * peak) / (2 * b);
                    end
                    reduced = 1'b1;
                end
                push_point(t0 + tv, negv, peak);
                if (!reduced && len > dv + db)
                begin
                    cruise_len = len - dv - db;
                    ta = (w != 0) ? time_quot(cruise_len, w) : TIME_INF;
                    push_point(t0 + tv + ta, negv, peak);
                end
                if (stop) push_point(t0 + tv + ta + tb, 1'b0, 64'd0);
            end
        end
        n = expected_pnts.size();
        for (int i = first; i < n; i++) expected_pnts[i].profile_complete = complete;
        expected_pnts[n - 1].last_point = 1'b1;
    endfunction

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 3)) - 32'd1;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return (32'($urandom_range(0, 40)) << 16) | ($urandom & 32'hFFFF)
                            ^ ({32{$urandom_range(0, 1) == 1}});
        endcase
    endfunction

    function automatic plan_req_t rand_req();
        plan_req_t r;
        r.start_velocity = rand_speed();
        r.target_velocity = rand_speed();
        r.stop_at_end = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: r.path_length = $urandom;
            1: r.path_length = $urandom_range(0, 3);
            default: r.path_length = 32'($urandom_range(0, 2000)) << 16 | ($urandom & 32'hFFFF);
        endcase
        return r;
    endfunction

    function automatic plan_req_t mk(input logic [31:0] l, input logic [31:0] v0,
                                     input logic [31:0] v, input int st);
        plan_req_t r;
        r.path_length = l;
        r.start_velocity = v0;
        r.target_velocity = v;
        r.stop_at_end = (st != 0);
        return r;
    endfunction

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_ACCEL) accel_q = val;
        else brake_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_pnts.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    // request driver; req_taken marks a request accepted at the last rising edge
    always @(negedge clk)
    begin
        if (req_valid && req_taken)
        begin
            if (gap_cycles == 0 && pending_reqs.size() != 0)
            begin
                req_data <= pending_reqs.pop_front();
                gap_cycles <= rand_gap();
            end
            else
                req_valid <= 1'b0;
        end
        else if (!req_valid)
        begin
            if (gap_cycles > 0)
                gap_cycles <= gap_cycles - 1;
            else if (pending_reqs.size() != 0)
            begin
                req_data <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                gap_cycles <= rand_gap();
            end
        end
    end

    // breakpoint receiver
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pnt_ready <= 1'b0;
        end
        else if (hold_off && !hold_done)
        begin
            // long hold so the block fills and stalls requests
            hold_cycles <= 3000;
            hold_done <= 1'b1;
            pnt_ready <= 1'b0;
        end
        else if (stall_cycles > 0)
        begin
            stall_cycles <= stall_cycles - 1;
            pnt_ready <= 1'b0;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            stall_cycles <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120)
                            : $urandom_range(1, 4);
            pnt_ready <= 1'b0;
        end
        else
            pnt_ready <= 1'b1;
    end

    // request acceptance and breakpoint check
    always @(posedge clk)
    begin
        plan_pnt_t e;
        req_taken <= rst_n && req_valid && req_ready;
        if (rst_n && req_valid && req_ready)
        begin
            plan_profile(req_data);
            reqs_accepted <= reqs_accepted + 1;
        end
        if (rst_n && pnt_valid && pnt_ready)
        begin
            if (expected_pnts.size() == 0)
            begin
                $display("%0t: unexpected breakpoint %h", $time, pnt_data);
                fail_count++;
            end
            else
            begin
                e = expected_pnts.pop_front();
                if (e.point_time !== pnt_data.point_time)
                begin
                    $display("%0t: point_time exp %h got %h", $time,
                             e.point_time, pnt_data.point_time);
                    fail_count++;
                end
                if (e.point_velocity !== pnt_data.point_velocity)
                begin
                    $display("%0t: point_velocity exp %h got %h", $time,
                             e.point_velocity, pnt_data.point_velocity);
                    fail_count++;
                end
                if (e.last_point !== pnt_data.last_point)
                begin
                    $display("%0t: last_point exp %b got %b", $time,
                             e.last_point, pnt_data.last_point);
                    fail_count++;
                end
                if (e.profile_complete !== pnt_data.profile_complete)
                begin
                    $display("%0t: profile_complete exp %b got %b", $time,
                             e.profile_complete, pnt_data.profile_complete);
                    fail_count++;
                end
                if (e.time_saturated !== pnt_data.time_saturated)
                begin
                    $display("%0t: time_saturated exp %b got %b", $time,
                             e.time_saturated, pnt_data.time_saturated);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        pnt_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ACCEL;
        cfg_data = '0;
        accel_q = LIMIT_RESET;
        brake_q = LIMIT_RESET;
        fail_count = 0;
        reqs_accepted = 0;
        stall_cycles = 0;
        gap_cycles = 0;
        hold_off = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, sign cases, short paths, zero cruise speed
        add_req(mk(32'd0, 32'd0, 32'd0, 0));
        add_req(mk(32'd0, 32'd0, 32'd0, 1));
        add_req(mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        add_req(mk(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
        add_req(mk(32'h0010_0000, 32'h0002_0000, 32'hFFFD_0000, 0));
        add_req(mk(32'h0100_0000, 32'hFFFE_0000, 32'h0003_0000, 1));
        add_req(mk(32'h0000_8000, 32'h0008_0000, 32'h0004_0000, 1));
        add_req(mk(32'h0000_8000, 32'h0008_0000, 32'hFFFC_0000, 0));
        add_req(mk(32'h0001_0000, 32'h0008_0000, 32'h0002_0000, 0));
        add_req(mk(32'h0002_0000, 32'h0000_0000, 32'h0010_0000, 1));
        add_req(mk(32'h0002_0000, 32'h0001_0000, 32'h0010_0000, 0));
        add_req(mk(32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 0));
        add_req(mk(32'h0100_0000, 32'h0003_0000, 32'h0000_0000, 1));
        add_req(mk(32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1));
        add_req(mk(32'h0040_0000, 32'h0000_0000, 32'hFFF0_0000, 1));
        drain();

        write_limit(REG_ACCEL, 32'd0);
        write_limit(REG_BRAKE, 32'd0);
        add_req(mk(32'h0000_0010, 32'h0000_0004, 32'h0000_0008, 1));
        add_req(mk(32'hFFFF_FFFF, 32'h0100_0000, 32'hFF00_0000, 0));
        add_req(mk(32'h0000_1000, 32'h0000_0000, 32'h0000_0100, 0));
        drain();

        write_limit(REG_ACCEL, 32'hFFFF_FFFF);
        write_limit(REG_BRAKE, 32'hFFFF_FFFF);
        add_req(mk(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        add_req(mk(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1));
        drain();

        // random phases over several limit settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_limit(REG_ACCEL, LIMIT_RESET); write_limit(REG_BRAKE, LIMIT_RESET); end
                1: begin write_limit(REG_ACCEL, 32'h0004_0000); write_limit(REG_BRAKE, 32'h0000_4000); end
                2: begin write_limit(REG_ACCEL, 32'd1); write_limit(REG_BRAKE, 32'h0010_0000); end
                3: begin write_limit(REG_ACCEL, $urandom); write_limit(REG_BRAKE, $urandom); end
                4: begin write_limit(REG_ACCEL, 32'($urandom_range(1, 1 << 20)));
                         write_limit(REG_BRAKE, 32'($urandom_range(1, 1 << 20))); end
                default: begin write_limit(REG_ACCEL, 32'h0002_8000);
                               write_limit(REG_BRAKE, 32'h0001_8000); end
            endcase
            for (int i = 0; i < 67; i++) add_req(rand_req());
            if (ph == 2)
            begin
                // receiver holds off once for a long stretch
                hold_off = 1'b1;
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
